@@ rtl/button_click_classifier_macros.svh @@
`ifndef BUTTON_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define BCC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bcc check failed");

// Check that cons holds in the cycle after ante.
`define BCC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bcc check failed");

`endif

@@ rtl/bcc_pkg.sv @@
package bcc_pkg;

    localparam logic [1:0] REQ_PRESS = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [7:0] CFG_IDX_ENABLE     = 8'd0;
    localparam logic [7:0] CFG_IDX_LONG_TICKS = 8'd1;
    localparam logic [7:0] CFG_IDX_GAP_TICKS  = 8'd2;
    localparam logic [7:0] CFG_IDX_DOUBLE_MIN = 8'd3;

    localparam logic       RST_ENABLE     = 1'b1;
    localparam logic [6:0] RST_LONG_TICKS = 7'd10;
    localparam logic [3:0] RST_GAP_TICKS  = 4'd5;
    localparam logic [7:0] RST_DOUBLE_MIN = 8'd2;

    localparam logic [6:0] DONE_MARK = 7'd100;
    localparam logic [6:0] PRESS_MAX = 7'd127;
    localparam logic [3:0] GAP_MAX   = 4'd15;
    localparam logic [7:0] REP_MAX   = 8'd255;

    typedef struct packed {
        logic       double_click_enable;
        logic [6:0] long_ticks;
        logic [3:0] gap_ticks;
        logic [7:0] double_min;
    } cfg_t;

    // Packed so that timer_running lands in bit 0.
    typedef struct packed {
        logic double_click;
        logic single_click;
        logic long_press;
        logic sense_armed;
        logic timer_running;
    } res_t;

endpackage

@@ rtl/bcc_cfg.sv @@
module bcc_cfg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [7:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    output bcc_pkg::cfg_t    cfg
);
    import bcc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_IDX_ENABLE:     cfg_next.double_click_enable = cfg_data[0];
                CFG_IDX_LONG_TICKS: cfg_next.long_ticks = cfg_data[6:0];
                CFG_IDX_GAP_TICKS:  cfg_next.gap_ticks = cfg_data[3:0];
                CFG_IDX_DOUBLE_MIN: cfg_next.double_min = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.double_click_enable <= RST_ENABLE;
            cfg_reg.long_ticks          <= RST_LONG_TICKS;
            cfg_reg.gap_ticks           <= RST_GAP_TICKS;
            cfg_reg.double_min          <= RST_DOUBLE_MIN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/bcc_core.sv @@
`include "button_click_classifier_macros.svh"

module bcc_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [1:0]       req_type,
    input  logic             pin_level,
    input  bcc_pkg::cfg_t    cfg,
    output bcc_pkg::res_t    res
);
    import bcc_pkg::*;

    logic       checking_reg,     checking_next;
    logic [6:0] press_ticks_reg,  press_ticks_next;
    logic [3:0] gap_timer_reg,    gap_timer_next;
    logic [7:0] repeat_ticks_reg, repeat_ticks_next;
    logic       long_flag_reg,    long_flag_next;
    logic       single_flag_reg,  single_flag_next;
    logic       double_flag_reg,  double_flag_next;
    logic [6:0] held_ticks;

    // Held counter advance, saturating, stops one past the threshold.
    assign held_ticks = (press_ticks_reg <= cfg.long_ticks && press_ticks_reg != PRESS_MAX)
                        ? press_ticks_reg + 7'd1 : press_ticks_reg;

    always_comb begin
        checking_next     = checking_reg;
        press_ticks_next  = press_ticks_reg;
        gap_timer_next    = gap_timer_reg;
        repeat_ticks_next = repeat_ticks_reg;
        long_flag_next    = long_flag_reg;
        single_flag_next  = single_flag_reg;
        double_flag_next  = double_flag_reg;
        unique case (req_type)
            REQ_PRESS: checking_next = 1'b1;
            REQ_TICK: begin
                if (checking_reg) begin
                    if (!cfg.double_click_enable) begin
                        if (pin_level) begin
                            press_ticks_next = held_ticks;
                            if (held_ticks == cfg.long_ticks) long_flag_next = 1'b1;
                        end else begin
                            checking_next     = 1'b0;
                            press_ticks_next  = '0;
                            gap_timer_next    = '0;
                            repeat_ticks_next = '0;
                        end
                    end else if (pin_level) begin
                        if (gap_timer_reg == '0) begin
                            press_ticks_next = held_ticks;
                            if (held_ticks == cfg.long_ticks) long_flag_next = 1'b1;
                        end else if (repeat_ticks_reg != REP_MAX) begin
                            repeat_ticks_next = repeat_ticks_reg + 8'd1;
                        end
                    end else if (press_ticks_reg < cfg.long_ticks) begin
                        if (gap_timer_reg <= cfg.gap_ticks) begin
                            if (gap_timer_reg != GAP_MAX) gap_timer_next = gap_timer_reg + 4'd1;
                            if (repeat_ticks_reg >= cfg.double_min) begin
                                double_flag_next = 1'b1;
                                press_ticks_next = DONE_MARK;
                            end
                        end
                        // window closes: single click unless the press was a glitch
                        if (gap_timer_next == cfg.gap_ticks) begin
                            if (press_ticks_next > 7'd1) single_flag_next = 1'b1;
                            press_ticks_next = DONE_MARK;
                        end
                    end else begin
                        checking_next     = 1'b0;
                        press_ticks_next  = '0;
                        gap_timer_next    = '0;
                        repeat_ticks_next = '0;
                    end
                end
            end
            REQ_CLEAR: begin
                long_flag_next   = 1'b0;
                single_flag_next = 1'b0;
                double_flag_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            checking_reg     <= 1'b0;
            press_ticks_reg  <= '0;
            gap_timer_reg    <= '0;
            repeat_ticks_reg <= '0;
            long_flag_reg    <= 1'b0;
            single_flag_reg  <= 1'b0;
            double_flag_reg  <= 1'b0;
        end else if (step) begin
            checking_reg     <= checking_next;
            press_ticks_reg  <= press_ticks_next;
            gap_timer_reg    <= gap_timer_next;
            repeat_ticks_reg <= repeat_ticks_next;
            long_flag_reg    <= long_flag_next;
            single_flag_reg  <= single_flag_next;
            double_flag_reg  <= double_flag_next;
        end
    end

    assign res.timer_running = checking_next;
    assign res.sense_armed   = !checking_next;
    assign res.long_press    = long_flag_next;
    assign res.single_click  = single_flag_next;
    assign res.double_click  = double_flag_next;

    `BCC_ASSERT_SAME(a_idle_counters_zero, aclk, aresetn, !checking_reg,
        press_ticks_reg == '0 && gap_timer_reg == '0 && repeat_ticks_reg == '0)
    `BCC_ASSERT_NEXT(a_clear_drops_flags, aclk, aresetn, step && req_type == REQ_CLEAR,
        !long_flag_reg && !single_flag_reg && !double_flag_reg)
    `BCC_ASSERT_NEXT(a_press_arms_check, aclk, aresetn, step && req_type == REQ_PRESS,
        checking_reg)

endmodule

@@ rtl/button_click_classifier.sv @@
// Push button classifier: long press, single click and double click flags.
//
// Input stream s_*: one transfer per press edge, timer tick or clear request.
//   s_tuser carries the request kind, s_tdata bit 0 the sampled pin on a tick.
// Result stream m_*: exactly one transfer per input transfer, in order, giving
//   checking state, edge-sense state and the three flags after that item.
// Config channel cfg_*: register writes by index, always ready; write only
//   while no items are in flight.
// An input register feeds the state update, whose result is captured in the
//   output register in the same cycle the state advances; a result reaches
//   m_tvalid through the input and output registers in turn. Throughput is one
//   item per cycle while the receiver does not stall.
// Reset (aresetn low, synchronous) empties both stages, restores the register
//   defaults and clears all counters and flags.
// When the receiver stalls the output register holds its result and the input
//   register still takes one more item; after that s_tready drops until the
//   result is taken. Nothing is dropped.
`include "button_click_classifier_macros.svh"

module button_click_classifier (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [0] pin_level, [7:1] zero
    input  logic [1:0] s_tuser,   // [1:0] req_type
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] timer_running, [1] sense_armed, [2] long_press,
                                  // [3] single_click, [4] double_click, [7:5] zero
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import bcc_pkg::*;

    logic       in_valid_reg;
    logic [1:0] req_type_reg;
    logic       pin_level_reg;
    logic       out_valid_reg;
    res_t       res_reg;
    res_t       res_next;
    cfg_t       cfg;
    logic       advance;

    // Move the held item into the result register when that slot frees up.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (advance) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_type_reg  <= s_tuser;
            pin_level_reg <= s_tdata[0];
        end
        if (advance) res_reg <= res_next;
    end

    bcc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .req_type  (req_type_reg),
        .pin_level (pin_level_reg),
        .cfg       (cfg),
        .res       (res_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res_reg};

    `BCC_ASSERT_SAME(a_sense_is_not_running, aclk, aresetn, m_tvalid,
        m_tdata[1] != m_tdata[0])
    `BCC_ASSERT_NEXT(a_advance_fills_output, aclk, aresetn, advance, m_tvalid)
    `BCC_ASSERT_NEXT(a_stall_keeps_input, aclk, aresetn, in_valid_reg && !advance,
        in_valid_reg && $stable(req_type_reg))

endmodule

@@ bench/click_checker.sv @@
`timescale 1ns / 100ps

module click_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic [1:0] s_tuser,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         errors,
    output int         pending
);
    import bcc_pkg::*;

    cfg_t       click_cfg;
    logic       in_check;
    logic [6:0] held_ticks;
    logic [3:0] gap_count;
    logic [7:0] repeat_count;
    logic       long_flag;
    logic       single_flag;
    logic       double_flag;
    res_t       expected_flags_q[$];
    int         results_seen;

    initial begin
        errors = 0;
        pending = 0;
        results_seen = 0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("mismatch at %0t ns, result %0d: %s", $time, results_seen, msg);
    endtask

    task automatic check_field(input string name, input logic want, input logic got);
        if (want !== got)
            report_mismatch($sformatf("%s expected %0b got %0b", name, want, got));
    endtask

    task automatic end_checking();
        in_check = 1'b0;
        held_ticks = '0;
        gap_count = '0;
        repeat_count = '0;
    endtask

    task automatic count_held_tick();
        if (held_ticks <= click_cfg.long_ticks && held_ticks < PRESS_MAX)
            held_ticks = held_ticks + 7'd1;
        if (held_ticks == click_cfg.long_ticks)
            long_flag = 1'b1;
    endtask

    task automatic tick_update(input logic pin);
        if (!in_check) begin
            // idle ticks change nothing
        end else if (!click_cfg.double_click_enable) begin
            if (pin)
                count_held_tick();
            else
                end_checking();
        end else if (pin) begin
            if (gap_count == 4'd0)
                count_held_tick();
            else if (repeat_count < REP_MAX)
                repeat_count = repeat_count + 8'd1;
        end else if (held_ticks < click_cfg.long_ticks) begin
            if (gap_count <= click_cfg.gap_ticks) begin
                if (gap_count < GAP_MAX)
                    gap_count = gap_count + 4'd1;
                if (repeat_count >= click_cfg.double_min) begin
                    double_flag = 1'b1;
                    held_ticks = DONE_MARK;
                end
            end
            // window closes: a press longer than one tick counts as a click
            if (gap_count == click_cfg.gap_ticks) begin
                if (held_ticks > 7'd1)
                    single_flag = 1'b1;
                held_ticks = DONE_MARK;
            end
        end else begin
            end_checking();
        end
    endtask

    task automatic classify_item(input logic [1:0] req, input logic pin, output res_t flags);
        case (req)
            REQ_PRESS: in_check = 1'b1;
            REQ_TICK:  tick_update(pin);
            REQ_CLEAR: begin
                long_flag = 1'b0;
                single_flag = 1'b0;
                double_flag = 1'b0;
            end
            default: ;
        endcase
        flags.timer_running = in_check;
        flags.sense_armed   = !in_check;
        flags.long_press    = long_flag;
        flags.single_click  = single_flag;
        flags.double_click  = double_flag;
    endtask

    always @(posedge aclk) begin : watch
        res_t want;
        res_t got;
        if (!aresetn) begin
            click_cfg.double_click_enable = RST_ENABLE;
            click_cfg.long_ticks = RST_LONG_TICKS;
            click_cfg.gap_ticks = RST_GAP_TICKS;
            click_cfg.double_min = RST_DOUBLE_MIN;
            end_checking();
            long_flag = 1'b0;
            single_flag = 1'b0;
            double_flag = 1'b0;
            expected_flags_q.delete();
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IDX_ENABLE:     click_cfg.double_click_enable = cfg_data[0];
                    CFG_IDX_LONG_TICKS: click_cfg.long_ticks = cfg_data[6:0];
                    CFG_IDX_GAP_TICKS:  click_cfg.gap_ticks = cfg_data[3:0];
                    CFG_IDX_DOUBLE_MIN: click_cfg.double_min = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                classify_item(s_tuser, s_tdata[0], want);
                expected_flags_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                got = res_t'(m_tdata[4:0]);
                if (expected_flags_q.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want = expected_flags_q.pop_front();
                    check_field("timer_running", want.timer_running, got.timer_running);
                    check_field("sense_armed", want.sense_armed, got.sense_armed);
                    check_field("long_press", want.long_press, got.long_press);
                    check_field("single_click", want.single_click, got.single_click);
                    check_field("double_click", want.double_click, got.double_click);
                end
            end
            pending <= expected_flags_q.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import bcc_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT = 300000;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [1:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_index;
    logic [7:0] cfg_data;

    int errors;
    int pending;
    int cycle_count;
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int holds_done;

    // stimulus-side view of the current settings, used only to shape gestures
    int cur_long;
    int cur_gap;
    int cur_dmin;

    button_click_classifier uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    click_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (holds_done != hold_requests) begin
                m_tready <= 1'b0;
                repeat (150) @(posedge aclk);
                holds_done++;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(input logic [1:0] req, input logic pin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {7'd0, pin};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_tick(input logic pin);
        if ($urandom_range(99) < 5)
            send_item(2'($urandom_range(3)), 1'($urandom_range(1)));
        send_item(REQ_TICK, pin);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 8'(value);
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input int en, input int long_t, input int gap_t, input int dmin);
        wait_idle();
        write_reg(CFG_IDX_ENABLE, en);
        write_reg(CFG_IDX_LONG_TICKS, long_t);
        write_reg(CFG_IDX_GAP_TICKS, gap_t);
        write_reg(CFG_IDX_DOUBLE_MIN, dmin);
        cfg_valid <= 1'b0;
        cur_long = long_t;
        cur_gap = gap_t;
        cur_dmin = dmin;
    endtask

    // Press, hold, gap-and-click rounds, release ticks; or 1-4 random items.
    task automatic run_gesture(input bit big_repeat);
        int held;
        int rounds;
        int highs;
        if (!big_repeat && $urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 4))
                send_item(2'($urandom_range(3)), 1'($urandom_range(1)));
            return;
        end
        send_item(REQ_PRESS, 1'($urandom_range(1)));
        if ($urandom_range(99) < ((cur_long <= 20) ? 30 : 6))
            held = $urandom_range(cur_long - 1, cur_long + 1);
        else
            held = $urandom_range(0, 4);
        repeat (held) send_tick(1'b1);
        rounds = big_repeat ? 1 : $urandom_range(0, 2);
        repeat (rounds) begin
            repeat ($urandom_range(1, cur_gap)) send_tick(1'b0);
            if ($urandom_range(1))
                send_item(REQ_PRESS, 1'($urandom_range(1)));
            if (big_repeat)
                highs = 260;
            else if ($urandom_range(99) < 20 && cur_dmin <= 8)
                highs = cur_dmin + $urandom_range(0, 1);
            else
                highs = $urandom_range(1, 3);
            repeat (highs) send_tick(1'b1);
        end
        repeat ($urandom_range(1, cur_gap + 2)) send_tick(1'b0);
    endtask

    task automatic run_until(input int target);
        while (items_sent < target) run_gesture(1'b0);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_PRESS;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IDX_ENABLE;
        cfg_data = '0;
        cycle_count = 0;
        items_sent = 0;
        hold_requests = 0;
        holds_done = 0;
        send_idle_pct = 27;
        recv_idle_pct = 79;
        cur_long = RST_LONG_TICKS;
        cur_gap = RST_GAP_TICKS;
        cur_dmin = RST_DOUBLE_MIN;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // idle ticks, unknown request and clear before any press
        send_item(REQ_TICK, 1'b1);
        send_item(REQ_TICK, 1'b0);
        send_item(REQ_UNKNOWN, 1'b1);
        send_item(REQ_CLEAR, 1'b1);
        // press twice, short hold, clear mid-check, then a double click
        send_item(REQ_PRESS, 1'b1);
        send_item(REQ_PRESS, 1'b0);
        send_item(REQ_TICK, 1'b1);
        send_item(REQ_TICK, 1'b1);
        send_item(REQ_TICK, 1'b0);
        send_item(REQ_CLEAR, 1'b0);
        send_item(REQ_TICK, 1'b1);
        send_item(REQ_TICK, 1'b1);
        send_item(REQ_TICK, 1'b0);
        send_item(REQ_TICK, 1'b0);
        // repeat click completes on the tick that closes the window
        send_item(REQ_PRESS, 1'b0);
        send_item(REQ_TICK, 1'b1);
        repeat (4) send_item(REQ_TICK, 1'b0);
        send_item(REQ_TICK, 1'b1);
        send_item(REQ_TICK, 1'b1);
        send_item(REQ_TICK, 1'b0);
        send_item(REQ_TICK, 1'b0);

        apply_setting(RST_ENABLE, RST_LONG_TICKS, RST_GAP_TICKS, RST_DOUBLE_MIN);
        run_until(items_sent + 70);
        apply_setting(1, 2, 1, 1);
        run_until(items_sent + 70);

        send_idle_pct = 79;
        recv_idle_pct = 27;
        apply_setting(0, 5, 3, 2);
        run_until(items_sent + 60);
        apply_setting(1, 99, 14, 255);
        run_gesture(1'b1);
        run_until(items_sent + 60);
        // threshold above the done marker: only a 127-tick hold ends checking
        apply_setting(1, 127, 15, 3);
        run_until(items_sent + 50);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setting(1, 6, 4, 2);
        hold_requests++;
        run_until(items_sent + 70);
        apply_setting($urandom_range(1), $urandom_range(2, 15), $urandom_range(1, 14),
                      $urandom_range(1, 4));
        run_until(items_sent + 60);

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
